// File: sv/gdr_pkg.sv
// ============================================================================
// gdr_pkg: shared types and constants of the grid DDA ray caster
// Holds the map geometry, the fixed-point constants, the queued item format,
// the configuration bundle, the divider handshake and the result bundle.
// ============================================================================
package gdr_pkg;

    localparam int MAP_DIM     = 16;
    localparam int CELL_PIXELS = 64;
    localparam int ANGLE_BITS  = 16;

    localparam int CELLS      = MAP_DIM * MAP_DIM;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int IDX_W      = $clog2(MAP_DIM);
    localparam int CRD_W      = $clog2(MAP_DIM + 1) + 1;
    localparam int CELL_SHIFT = $clog2(CELL_PIXELS);

    localparam int POS_W     = 10;
    localparam int FRAC_BITS = 6;
    localparam int TRIG_BITS = 14;
    localparam int TRIG_W    = TRIG_BITS + 1;
    localparam int TRIG_ONE  = 16384;
    localparam int DIST_SHIFT = 20;
    localparam int FAR_W     = 41;
    localparam logic [FAR_W-1:0] FAR_DIST = 41'h100_0000_0000;
    localparam int SIN_A = 25736;
    localparam int SIN_B = 10512;
    localparam int SIN_C = 1160;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);

    localparam int DIV_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic                  wr_ok;
        logic [ADDR_W-1:0]     cell_addr;
        logic                  cell_is_wall;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [ANGLE_BITS-1:0] ang_sin;
        logic [ANGLE_BITS-1:0] ang_cos;
        logic [ANGLE_BITS-1:0] ang_fish;
    } t_item;

    typedef struct packed {
        logic [7:0]  max_steps;
        logic [11:0] screen_height;
        logic [9:0]  height_scale;
    } t_cfg;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        hit;
        logic [3:0]  hit_col;
        logic [3:0]  hit_row;
        logic        hit_side;
        logic [15:0] collision_x;
        logic [15:0] collision_y;
        logic [16:0] ray_length;
        logic [16:0] corrected_length;
        logic [11:0] slice_height;
    } t_result;

endpackage

// File: sv/grid_dda_ray_caster.sv
// ============================================================================
// grid_dda_ray_caster: DDA grid ray caster with a one-bit wall map
// Map writes and ray casts enter through a command port, pass a short queue
// and are carried out by a sequencer around one shared divider.
// ============================================================================
//
// Channel      Direction  Handshake                Payload
// command      in         start high, busy low     kind, cell, position, angles
// config       in         i_cfg_valid, o_cfg_ready register index, data
// result       out        o_result_strobe          hit, cell, side, point,
//                                                  lengths, slice height
//
// A cast runs three trig evaluations, then up to seven passes through
// the bit-serial divider; the grid walk runs between those passes.
// Reset clears the configuration to its defaults and marks every map
// cell open through per-cell valid bits, so no clearing pass is needed.
// The front keeps taking transactions while the back works until the
// queue fills; each result is shown for one cycle and the receiver
// cannot stall it.
//
module grid_dda_ray_caster (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [7:0]  i_cell_index,
    input  logic        i_cell_is_wall,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [15:0] i_ray_angle,
    input  logic [15:0] i_view_angle,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic        o_hit,
    output logic [3:0]  o_hit_col,
    output logic [3:0]  o_hit_row,
    output logic        o_hit_side,
    output logic [15:0] o_collision_x,
    output logic [15:0] o_collision_y,
    output logic [16:0] o_ray_length,
    output logic [16:0] o_corrected_length,
    output logic [11:0] o_slice_height
);

    gdr_pkg::t_cfg     r_cfg;
    gdr_pkg::t_item    front_item;
    gdr_pkg::t_item    queue_item;
    gdr_pkg::t_div_req div_req;
    gdr_pkg::t_div_rsp div_rsp;
    gdr_pkg::t_result  result;
    logic push, full, queue_vld, pop;

    // The configuration registers take a write in any cycle; writes to an
    // index past the last register are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_steps     <= 8'd100;
            r_cfg.screen_height <= 12'd600;
            r_cfg.height_scale  <= 10'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gdr_pkg::CFG_MAX_STEPS:     r_cfg.max_steps     <= i_cfg_data[7:0];
                gdr_pkg::CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                gdr_pkg::CFG_HEIGHT_SCALE:  r_cfg.height_scale  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Front: registers each accepted transaction and prepares its angles.
    gdr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_cell_index   (i_cell_index),
        .i_cell_is_wall (i_cell_is_wall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_ray_angle    (i_ray_angle),
        .i_view_angle   (i_view_angle),
        .o_push         (push),
        .o_item         (front_item),
        .i_full         (full)
    );

    // Queue: decouples the command side from the long-running casts.
    gdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_vld   (queue_vld)
    );

    // Back: map storage and the cast sequencer.
    gdr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (queue_item),
        .i_item_vld      (queue_vld),
        .o_item_pop      (pop),
        .i_cfg           (r_cfg),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_result        (result),
        .o_result_strobe (o_result_strobe)
    );

    // Shared divider for step lengths, projections, lengths and slice height.
    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_hit              = result.hit;
    assign o_hit_col          = result.hit_col;
    assign o_hit_row          = result.hit_row;
    assign o_hit_side         = result.hit_side;
    assign o_collision_x      = result.collision_x;
    assign o_collision_y      = result.collision_y;
    assign o_ray_length       = result.ray_length;
    assign o_corrected_length = result.corrected_length;
    assign o_slice_height     = result.slice_height;

endmodule

// File: sv/gdr_front.sv
// ============================================================================
// gdr_front: input stage of the ray caster
// Registers each accepted transaction, checks the cell address of map writes
// and forms the three trig angles of a cast, then hands it to the queue.
// ============================================================================
module gdr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_kind,
    input  logic [7:0]           i_cell_index,
    input  logic                 i_cell_is_wall,
    input  logic [9:0]           i_pos_x,
    input  logic [9:0]           i_pos_y,
    input  logic [15:0]          i_ray_angle,
    input  logic [15:0]          i_view_angle,
    output logic                 o_push,
    output gdr_pkg::t_item       o_item,
    input  logic                 i_full
);

    logic           r_vld;
    gdr_pkg::t_item r_item;
    gdr_pkg::t_item item;
    logic           accept;
    logic [gdr_pkg::ANGLE_BITS-1:0] ra;
    logic [gdr_pkg::ANGLE_BITS-1:0] va;

    assign busy   = r_vld && i_full;
    assign accept = start && !busy;
    assign o_push = r_vld && !i_full;
    assign o_item = r_item;

    assign ra = i_ray_angle[gdr_pkg::ANGLE_BITS-1:0];
    assign va = i_view_angle[gdr_pkg::ANGLE_BITS-1:0];

    always_comb begin
        item.kind         = i_kind;
        item.wr_ok        = ({1'b0, i_cell_index} < 9'(gdr_pkg::CELLS));
        item.cell_addr    = gdr_pkg::ADDR_W'(i_cell_index);
        item.cell_is_wall = i_cell_is_wall;
        item.pos_x        = i_pos_x;
        item.pos_y        = i_pos_y;
        item.ang_sin      = ra;
        // Cosine is the sine a quarter turn later; the sum wraps on the circle.
        item.ang_cos      = ra + gdr_pkg::ANGLE_BITS'(gdr_pkg::QUARTER);
        item.ang_fish     = va - ra + gdr_pkg::ANGLE_BITS'(gdr_pkg::QUARTER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_vld  <= 1'b1;
                r_item <= item;
            end else if (o_push) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

// File: sv/gdr_fifo.sv
// ============================================================================
// gdr_fifo: short item queue between front and back
// Show-ahead queue of classified items so that either side may stall alone.
// ============================================================================
module gdr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gdr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output gdr_pkg::t_item o_item,
    output logic           o_vld
);

    localparam int PTR_W = $clog2(gdr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gdr_pkg::QUEUE_DEPTH + 1);

    gdr_pkg::t_item r_mem [gdr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(gdr_pkg::QUEUE_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(gdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(gdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/gdr_div.sv
// ============================================================================
// gdr_div: shared unsigned divider
// Restoring division, one quotient bit per cycle, done pulses with the result.
// ============================================================================
module gdr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdr_pkg::t_div_req i_req,
    output gdr_pkg::t_div_rsp o_rsp
);

    localparam int W     = gdr_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[W-1:0], r_quo[W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo <= {r_quo[W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/gdr_back.sv
// ============================================================================
// gdr_back: execution engine of the ray caster
// Applies map writes, and for a cast runs trig, DDA setup, the grid walk,
// the collision projection, the fisheye correction and the slice height.
// ============================================================================
module gdr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdr_pkg::t_item    i_item,
    input  logic              i_item_vld,
    output logic              o_item_pop,
    input  gdr_pkg::t_cfg     i_cfg,
    output gdr_pkg::t_div_req o_div_req,
    input  gdr_pkg::t_div_rsp i_div_rsp,
    output gdr_pkg::t_result  o_result,
    output logic              o_result_strobe
);

    localparam int AB    = gdr_pkg::ANGLE_BITS;
    localparam int TW    = gdr_pkg::TRIG_W;
    localparam int TB    = gdr_pkg::TRIG_BITS;
    localparam int FW    = gdr_pkg::FAR_W;
    localparam int CW    = gdr_pkg::CRD_W;
    localparam int DW    = gdr_pkg::DIV_W;
    localparam int BND_W = 14;
    localparam int COL_W = 34;
    localparam int ZW    = 40;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TZ, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
        ST_DGO, ST_DWAIT, ST_WALK, ST_TEST, ST_FIN, ST_COLL,
        ST_C1, ST_C2, ST_C3, ST_SH
    } t_state;

    typedef enum logic [1:0] {TR_SIN, TR_COS, TR_FISH} t_trig;

    typedef enum logic [2:0] {
        DV_STX, DV_HX, DV_STY, DV_HY, DV_PROJ, DV_LEN, DV_SLICE
    } t_dsel;

    t_state r_state;
    t_trig  r_tsel;
    t_dsel  r_dsel;
    gdr_pkg::t_item r_item;

    logic [TW-1:0] r_z, r_z2, r_asn, r_acs, r_acf;
    logic          r_tneg, r_sn_neg, r_cs_neg;
    logic [31:0]   r_p, r_plo;
    logic [FW-1:0] r_stx, r_sty, r_hx, r_hy;
    logic signed [CW-1:0] r_mx, r_my;
    logic [7:0]    r_steps;
    logic          r_hit, r_side, r_out_grid;
    logic [BND_W-1:0] r_d;
    logic signed [BND_W-1:0] r_bound;
    logic [DW-1:0] r_proj, r_len, r_corr;
    gdr_pkg::t_result r_res;
    logic          r_strobe;

    logic          r_map [gdr_pkg::CELLS];
    logic [gdr_pkg::CELLS-1:0] r_map_vld;
    logic          r_rd_wall, r_rd_vld;

    // ---------------- trig ----------------
    logic [AB-1:0] ang;
    logic [1:0]    quad;
    logic [AB-3:0] rr;
    logic [AB-2:0] arg;
    logic [ZW-1:0] z_wide;
    logic [TW-1:0] z_val;
    logic [TW-1:0] z2_val;
    logic [TW-1:0] t1_val, t2_val;
    logic [31:0]   s_val;
    logic [TW-1:0] mag;

    always_comb begin
        unique case (r_tsel)
            TR_SIN:  ang = r_item.ang_sin;
            TR_COS:  ang = r_item.ang_cos;
            default: ang = r_item.ang_fish;
        endcase
        quad   = ang[AB-1:AB-2];
        rr     = ang[AB-3:0];
        arg    = quad[0] ? ((AB-1)'(gdr_pkg::QUARTER) - {1'b0, rr}) : {1'b0, rr};
        z_wide = (ZW'(arg) << TB) >> (AB - 2);
        z_val  = (z_wide > ZW'(gdr_pkg::TRIG_ONE)) ? TW'(gdr_pkg::TRIG_ONE) : TW'(z_wide);
        z2_val = TW'(r_p >> TB);
        t1_val = TW'(gdr_pkg::SIN_B) - TW'(r_p >> TB);
        t2_val = TW'(gdr_pkg::SIN_A) - TW'(r_p >> TB);
        s_val  = r_p >> TB;
        mag    = (s_val > 32'(gdr_pkg::TRIG_ONE)) ? TW'(gdr_pkg::TRIG_ONE) : TW'(s_val);
    end

    // ---------------- signs and setup ----------------
    logic cs_pos, cs_neg, sn_pos, sn_neg;
    logic [gdr_pkg::CELL_SHIFT:0] dx, dy;
    logic [gdr_pkg::CELL_SHIFT-1:0] xfrac, yfrac;

    assign cs_pos = !r_cs_neg && (r_acs != '0);
    assign cs_neg =  r_cs_neg && (r_acs != '0);
    assign sn_pos = !r_sn_neg && (r_asn != '0);
    assign sn_neg =  r_sn_neg && (r_asn != '0);
    assign xfrac  = r_item.pos_x[gdr_pkg::CELL_SHIFT-1:0];
    assign yfrac  = r_item.pos_y[gdr_pkg::CELL_SHIFT-1:0];
    assign dx = cs_pos ? ((gdr_pkg::CELL_SHIFT+1)'(gdr_pkg::CELL_PIXELS) - {1'b0, xfrac})
                       : {1'b0, xfrac};
    assign dy = sn_pos ? {1'b0, yfrac}
                       : ((gdr_pkg::CELL_SHIFT+1)'(gdr_pkg::CELL_PIXELS) - {1'b0, yfrac});

    // ---------------- divider operands ----------------
    logic [TW-1:0] fin_den;
    logic          skip;
    logic [FW-1:0] special;
    logic          store_en;
    logic [FW-1:0] store_q;

    always_comb begin
        if (r_side) begin
            fin_den = (r_asn != '0) ? r_asn : TW'(1);
        end else begin
            fin_den = (r_acs != '0) ? r_acs : TW'(1);
        end
        o_div_req.num = '0;
        o_div_req.den = '0;
        skip    = 1'b0;
        special = gdr_pkg::FAR_DIST;
        unique case (r_dsel)
            DV_STX: begin
                o_div_req.num = DW'(gdr_pkg::CELL_PIXELS) << gdr_pkg::DIST_SHIFT;
                o_div_req.den = DW'(r_acs);
                skip = (r_acs == '0);
            end
            DV_HX: begin
                o_div_req.num = DW'(dx) << gdr_pkg::DIST_SHIFT;
                o_div_req.den = DW'(r_acs);
                skip = (r_acs == '0);
            end
            DV_STY: begin
                o_div_req.num = DW'(gdr_pkg::CELL_PIXELS) << gdr_pkg::DIST_SHIFT;
                o_div_req.den = DW'(r_asn);
                skip = (r_asn == '0);
            end
            DV_HY: begin
                o_div_req.num = DW'(dy) << gdr_pkg::DIST_SHIFT;
                o_div_req.den = DW'(r_asn);
                skip = (r_asn == '0);
            end
            DV_PROJ: begin
                o_div_req.num = r_p << gdr_pkg::FRAC_BITS;
                o_div_req.den = DW'(fin_den);
            end
            DV_LEN: begin
                o_div_req.num = DW'(r_d) << gdr_pkg::DIST_SHIFT;
                o_div_req.den = DW'(fin_den);
            end
            default: begin
                o_div_req.num = r_p << gdr_pkg::FRAC_BITS;
                o_div_req.den = r_corr;
                skip    = (r_corr == '0);
                special = FW'(i_cfg.screen_height);
            end
        endcase
        o_div_req.go = (r_state == ST_DGO) && !skip;
        store_en = ((r_state == ST_DGO) && skip) || ((r_state == ST_DWAIT) && i_div_rsp.done);
        store_q  = (r_state == ST_DGO) ? special : FW'(i_div_rsp.quot);
    end

    // ---------------- walk ----------------
    logic          take_x;
    logic [FW:0]   sum_x, sum_y;
    logic signed [CW-1:0] nx, ny, wx, wy;
    logic          in_grid;
    logic [gdr_pkg::ADDR_W-1:0] walk_addr;
    logic          hit_now;

    always_comb begin
        take_x  = (r_hx < r_hy);
        sum_x   = {1'b0, r_hx} + {1'b0, r_stx};
        sum_y   = {1'b0, r_hy} + {1'b0, r_sty};
        nx      = cs_pos ? (r_mx + CW'(1)) : (r_mx - CW'(1));
        ny      = sn_pos ? (r_my - CW'(1)) : (r_my + CW'(1));
        wx      = take_x ? nx : r_mx;
        wy      = take_x ? r_my : ny;
        in_grid = (wx >= 0) && (wx < CW'(gdr_pkg::MAP_DIM))
               && (wy >= 0) && (wy < CW'(gdr_pkg::MAP_DIM));
        walk_addr = gdr_pkg::ADDR_W'(unsigned'(wy) * gdr_pkg::MAP_DIM + unsigned'(wx));
        hit_now = r_out_grid || (r_rd_wall && r_rd_vld);
    end

    // ---------------- collision ----------------
    logic signed [CW-1:0]    cell_c;
    logic                    plus_one;
    logic signed [BND_W-1:0] cell_ext, bound, pos_ext, diff;
    logic [BND_W-1:0]        d_abs;
    logic signed [COL_W-1:0] base_x, base_y, proj_s, bnd64, cx_w, cy_w;

    function automatic logic [15:0] clamp16(input logic signed [COL_W-1:0] v);
        if (v < 0) begin
            return 16'd0;
        end else if (v > COL_W'(65535)) begin
            return 16'hffff;
        end else begin
            return v[15:0];
        end
    endfunction

    always_comb begin
        cell_c   = r_side ? r_my : r_mx;
        plus_one = r_side ? !sn_neg : !cs_pos;
        cell_ext = BND_W'(cell_c);
        bound    = (cell_ext + BND_W'(plus_one)) <<< gdr_pkg::CELL_SHIFT;
        pos_ext  = signed'(BND_W'(r_side ? r_item.pos_y : r_item.pos_x));
        diff     = bound - pos_ext;
        d_abs    = diff[BND_W-1] ? BND_W'(-diff) : BND_W'(diff);
        base_x   = signed'(COL_W'(r_item.pos_x) << gdr_pkg::FRAC_BITS);
        base_y   = signed'(COL_W'(r_item.pos_y) << gdr_pkg::FRAC_BITS);
        proj_s   = signed'(COL_W'(r_proj));
        bnd64    = COL_W'(r_bound) <<< gdr_pkg::FRAC_BITS;
        if (r_side) begin
            cy_w = bnd64;
            cx_w = cs_neg ? (base_x - proj_s) : (base_x + proj_s);
        end else begin
            cx_w = bnd64;
            cy_w = sn_neg ? (base_y + proj_s) : (base_y - proj_s);
        end
    end

    logic [47:0] corr_w;
    assign corr_w = (({16'd0, r_p} << 16) + {16'd0, r_plo}) >> TB;

    // ---------------- map memory ----------------
    logic map_we;
    assign o_item_pop = (r_state == ST_IDLE) && i_item_vld;
    assign map_we = o_item_pop && (i_item.kind == gdr_pkg::KIND_WRITE) && i_item.wr_ok;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[i_item.cell_addr] <= i_item.cell_is_wall;
        end
        if (r_state == ST_WALK) begin
            r_rd_wall <= r_map[walk_addr];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_strobe  <= 1'b0;
            r_map_vld <= '0;
            r_tsel    <= TR_SIN;
            r_dsel    <= DV_STX;
        end else begin
            r_strobe <= 1'b0;
            if (map_we) begin
                r_map_vld[i_item.cell_addr] <= 1'b1;
            end
            if (r_state == ST_WALK) begin
                r_rd_vld <= r_map_vld[walk_addr];
            end
            if (store_en) begin
                unique case (r_dsel)
                    DV_STX:  r_stx <= store_q;
                    DV_HX:   r_hx  <= store_q;
                    DV_STY:  r_sty <= store_q;
                    DV_HY:   r_hy  <= store_q;
                    DV_PROJ: r_proj <= DW'(store_q);
                    DV_LEN:  r_len  <= DW'(store_q);
                    default: r_res.slice_height <=
                        (store_q > FW'(i_cfg.screen_height)) ? i_cfg.screen_height
                                                             : 12'(store_q);
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_vld && (i_item.kind == gdr_pkg::KIND_CAST)) begin
                        r_item  <= i_item;
                        r_mx    <= CW'(i_item.pos_x >> gdr_pkg::CELL_SHIFT);
                        r_my    <= CW'(i_item.pos_y >> gdr_pkg::CELL_SHIFT);
                        r_tsel  <= TR_SIN;
                        r_state <= ST_TZ;
                    end
                end
                ST_TZ: begin
                    r_z     <= z_val;
                    r_tneg  <= quad[1];
                    r_state <= ST_T1;
                end
                ST_T1: begin
                    r_p     <= 32'(r_z) * 32'(r_z);
                    r_state <= ST_T2;
                end
                ST_T2: begin
                    r_z2    <= z2_val;
                    r_p     <= 32'(gdr_pkg::SIN_C) * 32'(z2_val);
                    r_state <= ST_T3;
                end
                ST_T3: begin
                    r_p     <= 32'(t1_val) * 32'(r_z2);
                    r_state <= ST_T4;
                end
                ST_T4: begin
                    r_p     <= 32'(t2_val) * 32'(r_z);
                    r_state <= ST_T5;
                end
                ST_T5: begin
                    unique case (r_tsel)
                        TR_SIN: begin
                            r_asn    <= mag;
                            r_sn_neg <= r_tneg;
                            r_tsel   <= TR_COS;
                            r_state  <= ST_TZ;
                        end
                        TR_COS: begin
                            r_acs    <= mag;
                            r_cs_neg <= r_tneg;
                            r_tsel   <= TR_FISH;
                            r_state  <= ST_TZ;
                        end
                        default: begin
                            r_acf   <= mag;
                            r_dsel  <= DV_STX;
                            r_state <= ST_DGO;
                        end
                    endcase
                end
                ST_DGO, ST_DWAIT: begin
                    if (r_state == ST_DGO && !skip) begin
                        r_state <= ST_DWAIT;
                    end else if (store_en) begin
                        unique case (r_dsel)
                            DV_STX: begin
                                r_dsel  <= DV_HX;
                                r_state <= ST_DGO;
                            end
                            DV_HX: begin
                                r_dsel  <= DV_STY;
                                r_state <= ST_DGO;
                            end
                            DV_STY: begin
                                r_dsel  <= DV_HY;
                                r_state <= ST_DGO;
                            end
                            DV_HY: begin
                                r_steps <= '0;
                                r_hit   <= 1'b0;
                                r_side  <= 1'b0;
                                r_state <= (i_cfg.max_steps == '0) ? ST_FIN : ST_WALK;
                            end
                            DV_PROJ: begin
                                r_dsel  <= DV_LEN;
                                r_state <= ST_DGO;
                            end
                            DV_LEN: begin
                                r_state <= ST_COLL;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_state  <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (take_x) begin
                        r_mx   <= nx;
                        r_hx   <= (sum_x > {1'b0, gdr_pkg::FAR_DIST}) ? gdr_pkg::FAR_DIST
                                                                      : FW'(sum_x);
                        r_side <= 1'b0;
                    end else begin
                        r_my   <= ny;
                        r_hy   <= (sum_y > {1'b0, gdr_pkg::FAR_DIST}) ? gdr_pkg::FAR_DIST
                                                                      : FW'(sum_y);
                        r_side <= 1'b1;
                    end
                    r_steps    <= r_steps + 8'd1;
                    r_out_grid <= !in_grid;
                    r_state    <= ST_TEST;
                end
                ST_TEST: begin
                    r_hit <= hit_now;
                    if (hit_now || (r_steps == i_cfg.max_steps)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_FIN: begin
                    r_res.hit      <= r_hit;
                    r_res.hit_col  <= r_mx[3:0];
                    r_res.hit_row  <= r_my[3:0];
                    r_res.hit_side <= r_side;
                    r_bound        <= bound;
                    r_d            <= d_abs;
                    if (r_steps == '0) begin
                        r_len   <= '0;
                        r_res.collision_x <= clamp16(base_x);
                        r_res.collision_y <= clamp16(base_y);
                        r_state <= ST_C1;
                    end else begin
                        r_p     <= 32'(d_abs) * 32'(r_side ? r_acs : r_asn);
                        r_dsel  <= DV_PROJ;
                        r_state <= ST_DGO;
                    end
                end
                ST_COLL: begin
                    r_res.collision_x <= clamp16(cx_w);
                    r_res.collision_y <= clamp16(cy_w);
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_p     <= 32'(r_len[15:0]) * 32'(r_acf);
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_plo   <= r_p;
                    r_p     <= 32'(r_len[31:16]) * 32'(r_acf);
                    r_state <= ST_C3;
                end
                ST_C3: begin
                    r_corr <= DW'(corr_w);
                    r_res.ray_length <= (r_len > 32'd131071) ? 17'h1ffff : r_len[16:0];
                    r_res.corrected_length <=
                        (corr_w > 48'd131071) ? 17'h1ffff : corr_w[16:0];
                    r_state <= ST_SH;
                end
                ST_SH: begin
                    r_p     <= 32'(i_cfg.screen_height) * 32'(i_cfg.height_scale);
                    r_dsel  <= DV_SLICE;
                    r_state <= ST_DGO;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result        = r_res;
    assign o_result_strobe = r_strobe;

endmodule
